### rtl/crs_pkg.sv
// Shared types, widths and codes of the Catmull-Rom spline evaluator.
`timescale 1ns / 1ps
`default_nettype none

package crs_pkg;

  localparam int MAX_POINTS_DEF = 256;

  localparam int PFB = 16;
  localparam int POS_W = 24;
  localparam int IDX_W = 8;
  localparam int COORD_W = 32;
  localparam int COUNT_W = 9;
  localparam int F2_W = 2 * PFB;
  localparam int F3_W = 3 * PFB;

  localparam int WEIGHT_FRAC = 28;
  localparam int WEIGHT_W = 32;
  localparam int NUM_W = 3 * PFB + 6;
  localparam int PROD_W = COORD_W + WEIGHT_W;
  localparam int POS_SHIFT = 3 * PFB - WEIGHT_FRAC;
  localparam int TAN_SHIFT = 2 * PFB - WEIGHT_FRAC;
  localparam int SUM_SHIFT = WEIGHT_FRAC + 1;

  localparam int ADDR_W = 3;
  localparam int REG_W = ADDR_W - 2;
  localparam logic [REG_W-1:0] REG_LOOPED = 1'd0;
  localparam logic [REG_W-1:0] REG_COUNT = 1'd1;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd4;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_POSITION = 2'd1;
  localparam logic [1:0] OP_TANGENT = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_SAT = 2'd2;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [WEIGHT_W-1:0] wval_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [IDX_W-1:0] point_index;
    coord_t point_x;
    coord_t point_y;
    coord_t point_z;
    logic [POS_W-1:0] position;
  } cmd_t;

  typedef struct packed {
    coord_t result_x;
    coord_t result_y;
    coord_t result_z;
    logic [1:0] status;
  } res_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  typedef struct packed {
    logic eval;
    logic tangent;
    logic [1:0] status;
  } ctl_t;

  typedef struct packed {
    ctl_t ctl;
    logic [PFB-1:0] f;
    logic [F2_W-1:0] f2;
    logic [F3_W-1:0] f3;
    point_t [3:0] pts;
  } fch_t;

  typedef struct packed {
    ctl_t ctl;
    wval_t [3:0] w;
    point_t [3:0] pts;
  } wgt_t;

endpackage

`default_nettype wire

### rtl/crs_ram.sv
// Point table memory with one write port and two registered read ports.
`timescale 1ns / 1ps
`default_nettype none

module crs_ram
  import crs_pkg::*;
#(
  parameter int DEPTH = MAX_POINTS_DEF,
  parameter int AW = $clog2(MAX_POINTS_DEF)
) (
  input wire logic clk,
  input wire logic we,
  input wire logic [AW-1:0] waddr,
  input wire point_t wdata,
  input wire logic re,
  input wire logic [AW-1:0] raddr_a,
  input wire logic [AW-1:0] raddr_b,
  output point_t rdata_a,
  output point_t rdata_b
);

  point_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

`default_nettype wire

### rtl/crs_fetch.sv
// Index and range stage followed by the point table access stage.
`timescale 1ns / 1ps
`default_nettype none

module crs_fetch
  import crs_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int AW = $clog2(MAX_POINTS_DEF)
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic looped,
  input wire logic [COUNT_W-1:0] point_count,
  input wire logic cmd_valid,
  output logic cmd_ready,
  input wire cmd_t cmd,
  output logic fch_valid,
  input wire logic fch_ready,
  output fch_t fch
);

  localparam int CW = (((AW + 1) > COUNT_W) ? (AW + 1) : COUNT_W) + 1;

  logic [CW-1:0] n;
  logic [CW-1:0] seg;
  logic [CW-1:0] seg1;
  logic [CW-1:0] seg2;
  logic [CW-1:0] slot;
  logic [CW-1:0] idx [4];
  logic in_range;
  logic slot_ok;
  ctl_t ctl_next;

  logic va;
  logic vb;
  logic load_a;
  logic load_b;
  ctl_t ctl_a;
  logic wr_a;
  logic [AW-1:0] waddr_a;
  point_t wdata_a;
  logic [AW-1:0] addr_a [4];
  logic [PFB-1:0] f_a;
  logic [F2_W-1:0] f2_a;
  ctl_t ctl_b;
  logic [PFB-1:0] f_b;
  logic [F2_W-1:0] f2_b;
  logic [F3_W-1:0] f3_b;
  point_t rd [4];

  always_comb begin
    n = (CW'(point_count) < CW'(MAX_POINTS)) ? CW'(point_count) : CW'(MAX_POINTS);
    seg = CW'(cmd.position[POS_W-1:PFB]);
    seg1 = seg + CW'(1);
    seg2 = seg + CW'(2);
    slot = CW'(cmd.point_index);
    slot_ok = slot < CW'(MAX_POINTS);
    if (looped) begin
      in_range = seg < n;
      idx[0] = (seg == '0) ? n - CW'(1) : seg - CW'(1);
      idx[1] = seg;
      idx[2] = (seg1 == n) ? '0 : seg1;
      idx[3] = (seg2 >= n) ? (((seg2 - n) >= n) ? seg2 - n - n : seg2 - n) : seg2;
    end else begin
      in_range = (seg + CW'(3)) < n;
      idx[0] = seg;
      idx[1] = seg1;
      idx[2] = seg2;
      idx[3] = seg + CW'(3);
    end
    ctl_next.tangent = cmd.operation == OP_TANGENT;
    ctl_next.eval = 1'b0;
    ctl_next.status = ST_OK;
    case (cmd.operation)
      OP_WRITE: begin
        ctl_next.status = slot_ok ? ST_OK : ST_RANGE;
      end
      OP_POSITION, OP_TANGENT: begin
        ctl_next.eval = in_range;
        ctl_next.status = in_range ? ST_OK : ST_RANGE;
      end
      default: begin
        ctl_next.status = ST_OK;
      end
    endcase
  end

  assign load_b = !vb || fch_ready;
  assign load_a = !va || load_b;
  assign cmd_ready = load_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
    end else begin
      if (load_a) begin
        va <= cmd_valid;
      end
      if (load_b) begin
        vb <= va;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_a) begin
      ctl_a <= ctl_next;
      wr_a <= (cmd.operation == OP_WRITE) && slot_ok;
      waddr_a <= slot[AW-1:0];
      wdata_a <= '{x: cmd.point_x, y: cmd.point_y, z: cmd.point_z};
      for (int k = 0; k < 4; k++) begin
        addr_a[k] <= idx[k][AW-1:0];
      end
      f_a <= cmd.position[PFB-1:0];
      f2_a <= F2_W'(cmd.position[PFB-1:0]) * F2_W'(cmd.position[PFB-1:0]);
    end
    if (load_b) begin
      ctl_b <= ctl_a;
      f_b <= f_a;
      f2_b <= f2_a;
      f3_b <= F3_W'(f2_a) * F3_W'(f_a);
    end
  end

  crs_ram #(
    .DEPTH(MAX_POINTS),
    .AW(AW)
  ) u_ram_lo (
    .clk(clk),
    .we(va && wr_a && load_b),
    .waddr(waddr_a),
    .wdata(wdata_a),
    .re(load_b),
    .raddr_a(addr_a[0]),
    .raddr_b(addr_a[1]),
    .rdata_a(rd[0]),
    .rdata_b(rd[1])
  );

  crs_ram #(
    .DEPTH(MAX_POINTS),
    .AW(AW)
  ) u_ram_hi (
    .clk(clk),
    .we(va && wr_a && load_b),
    .waddr(waddr_a),
    .wdata(wdata_a),
    .re(load_b),
    .raddr_a(addr_a[2]),
    .raddr_b(addr_a[3]),
    .rdata_a(rd[2]),
    .rdata_b(rd[3])
  );

  always_comb begin
    fch.ctl = ctl_b;
    fch.f = f_b;
    fch.f2 = f2_b;
    fch.f3 = f3_b;
    for (int k = 0; k < 4; k++) begin
      fch.pts[k] = rd[k];
    end
  end

  assign fch_valid = vb;

endmodule

`default_nettype wire

### rtl/crs_weight.sv
// Basis numerator stage and rounded weight stage.
`timescale 1ns / 1ps
`default_nettype none

module crs_weight
  import crs_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic fch_valid,
  output logic fch_ready,
  input wire fch_t fch,
  output logic wgt_valid,
  input wire logic wgt_ready,
  output wgt_t wgt
);

  localparam logic signed [NUM_W-1:0] S_SQ = NUM_W'(1) << (2 * PFB);
  localparam logic signed [NUM_W-1:0] S_CUBE2 = NUM_W'(1) << (3 * PFB + 1);
  localparam logic signed [NUM_W-1:0] POS_HALF = NUM_W'(1) << (POS_SHIFT - 1);
  localparam logic signed [NUM_W-1:0] TAN_HALF = NUM_W'(1) << (TAN_SHIFT - 1);

  logic signed [NUM_W-1:0] f1s;
  logic signed [NUM_W-1:0] f2s;
  logic signed [NUM_W-1:0] f3s;
  logic signed [NUM_W-1:0] num_next [4];
  logic signed [NUM_W-1:0] wide [4];

  logic vc;
  logic vd;
  logic load_c;
  logic load_d;
  ctl_t ctl_c;
  point_t [3:0] pts_c;
  logic signed [NUM_W-1:0] num_c [4];
  ctl_t ctl_d;
  point_t [3:0] pts_d;
  wval_t [3:0] w_d;

  always_comb begin
    f1s = NUM_W'(fch.f);
    f2s = NUM_W'(fch.f2);
    f3s = NUM_W'(fch.f3);
    if (fch.ctl.tangent) begin
      num_next[0] = (f1s <<< (PFB + 2)) - ((f2s <<< 1) + f2s) - S_SQ;
      num_next[1] = ((f2s <<< 3) + f2s) - ((f1s <<< (PFB + 3)) + (f1s <<< (PFB + 1)));
      num_next[2] = (f1s <<< (PFB + 3)) + S_SQ - ((f2s <<< 3) + f2s);
      num_next[3] = ((f2s <<< 1) + f2s) - (f1s <<< (PFB + 1));
    end else begin
      num_next[0] = (f2s <<< (PFB + 1)) - f3s - (f1s <<< (2 * PFB));
      num_next[1] = ((f3s <<< 1) + f3s) - ((f2s <<< (PFB + 2)) + (f2s <<< PFB)) + S_CUBE2;
      num_next[2] = (f2s <<< (PFB + 2)) + (f1s <<< (2 * PFB)) - ((f3s <<< 1) + f3s);
      num_next[3] = f3s - (f2s <<< PFB);
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (ctl_c.tangent) begin
        wide[k] = (num_c[k] + TAN_HALF) >>> TAN_SHIFT;
      end else begin
        wide[k] = (num_c[k] + POS_HALF) >>> POS_SHIFT;
      end
    end
  end

  assign load_d = !vd || wgt_ready;
  assign load_c = !vc || load_d;
  assign fch_ready = load_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
      vd <= 1'b0;
    end else begin
      if (load_c) begin
        vc <= fch_valid;
      end
      if (load_d) begin
        vd <= vc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_c) begin
      ctl_c <= fch.ctl;
      pts_c <= fch.pts;
      for (int k = 0; k < 4; k++) begin
        num_c[k] <= num_next[k];
      end
    end
    if (load_d) begin
      ctl_d <= ctl_c;
      pts_d <= pts_c;
      for (int k = 0; k < 4; k++) begin
        w_d[k] <= wide[k][WEIGHT_W-1:0];
      end
    end
  end

  assign wgt_valid = vd;
  assign wgt.ctl = ctl_d;
  assign wgt.w = w_d;
  assign wgt.pts = pts_d;

endmodule

`default_nettype wire

### rtl/crs_combine.sv
// Weighted sum of four points per coordinate with rounding and saturation.
`timescale 1ns / 1ps
`default_nettype none

module crs_combine
  import crs_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic wgt_valid,
  output logic wgt_ready,
  input wire wgt_t wgt,
  output logic res_valid,
  input wire logic res_ready,
  output res_t res
);

  localparam int SUM_W = PROD_W + 1;
  localparam int ACC_W = PROD_W + 2;
  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (SUM_SHIFT - 1);
  localparam logic signed [ACC_W-1:0] SAT_MAX =
    {{(ACC_W - COORD_W + 1){1'b0}}, {(COORD_W - 1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_MIN =
    {{(ACC_W - COORD_W + 1){1'b1}}, {(COORD_W - 1){1'b0}}};

  logic ve;
  logic vf;
  logic vg;
  logic load_e;
  logic load_f;
  logic load_g;
  ctl_t ctl_e;
  ctl_t ctl_f;
  logic signed [PROD_W-1:0] prod_e [3][4];
  logic signed [SUM_W-1:0] s01_f [3];
  logic signed [SUM_W-1:0] s23_f [3];
  logic signed [ACC_W-1:0] acc [3];
  logic signed [ACC_W-1:0] q [3];
  coord_t val [3];
  logic any_sat;
  res_t res_next;

  always_comb begin
    any_sat = 1'b0;
    for (int c = 0; c < 3; c++) begin
      acc[c] = ACC_W'(s01_f[c]) + ACC_W'(s23_f[c]) + ROUND_HALF;
      q[c] = acc[c] >>> SUM_SHIFT;
      if (q[c] > SAT_MAX) begin
        val[c] = SAT_MAX[COORD_W-1:0];
        any_sat = 1'b1;
      end else if (q[c] < SAT_MIN) begin
        val[c] = SAT_MIN[COORD_W-1:0];
        any_sat = 1'b1;
      end else begin
        val[c] = q[c][COORD_W-1:0];
      end
    end
    if (ctl_f.eval) begin
      res_next.result_x = val[0];
      res_next.result_y = val[1];
      res_next.result_z = val[2];
      res_next.status = any_sat ? ST_SAT : ST_OK;
    end else begin
      res_next.result_x = '0;
      res_next.result_y = '0;
      res_next.result_z = '0;
      res_next.status = ctl_f.status;
    end
  end

  assign load_g = !vg || res_ready;
  assign load_f = !vf || load_g;
  assign load_e = !ve || load_f;
  assign wgt_ready = load_e;

  always_ff @(posedge clk) begin
    if (rst) begin
      ve <= 1'b0;
      vf <= 1'b0;
      vg <= 1'b0;
    end else begin
      if (load_e) begin
        ve <= wgt_valid;
      end
      if (load_f) begin
        vf <= ve;
      end
      if (load_g) begin
        vg <= vf;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_e) begin
      ctl_e <= wgt.ctl;
      for (int k = 0; k < 4; k++) begin
        prod_e[0][k] <= PROD_W'($signed(wgt.pts[k].x)) * PROD_W'($signed(wgt.w[k]));
        prod_e[1][k] <= PROD_W'($signed(wgt.pts[k].y)) * PROD_W'($signed(wgt.w[k]));
        prod_e[2][k] <= PROD_W'($signed(wgt.pts[k].z)) * PROD_W'($signed(wgt.w[k]));
      end
    end
    if (load_f) begin
      ctl_f <= ctl_e;
      for (int c = 0; c < 3; c++) begin
        s01_f[c] <= SUM_W'(prod_e[c][0]) + SUM_W'(prod_e[c][1]);
        s23_f[c] <= SUM_W'(prod_e[c][2]) + SUM_W'(prod_e[c][3]);
      end
    end
    if (load_g) begin
      res <= res_next;
    end
  end

  assign res_valid = vg;

endmodule

`default_nettype wire

### rtl/catmull_rom_spline_evaluator.sv
// Top level of the Catmull-Rom spline evaluator: register port and pipeline.
//
// Items enter on the cmd channel (valid/ready) and leave on the res channel.
// A write item stores one control point; a position or tangent item reads
// four neighboring points and returns their weighted sum. Every item,
// including writes and out-of-range requests, gives exactly one result.
// The pipeline has seven register stages: index and range check with f*f,
// point table read with f*f*f, basis numerators, rounded weights, the
// twelve point-by-weight products, pair sums, and the final sum with
// rounding and saturation in the output register. One item is accepted
// every cycle unless every stage is full and res_ready is low. The table
// keeps two copies, each with two read ports, so the four points of one
// item come out of the table together.
// When res_ready is low, results pile up stage by stage, bubbles are
// squeezed out, and cmd_ready falls only once every stage holds an item.
// Reset empties the pipeline and sets looped to 0 and point_count to 4;
// the point table is not cleared, so a point must be written before use.
// Registers: looped at byte address 0, point_count at byte address 4.
`timescale 1ns / 1ps
`default_nettype none

module catmull_rom_spline_evaluator
  import crs_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic psel,
  input wire logic penable,
  input wire logic pwrite,
  input wire logic [ADDR_W-1:0] paddr,
  input wire logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready,
  input wire logic cmd_valid,
  output logic cmd_ready,
  input wire cmd_t cmd,
  output logic res_valid,
  input wire logic res_ready,
  output res_t res
);

  localparam int AW = $clog2(MAX_POINTS);

  logic looped;
  logic [COUNT_W-1:0] point_count;
  logic [REG_W-1:0] reg_sel;
  logic fch_valid;
  logic fch_ready;
  fch_t fch;
  logic wgt_valid;
  logic wgt_ready;
  wgt_t wgt;

  assign reg_sel = paddr[ADDR_W-1:2];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      looped <= 1'b0;
      point_count <= COUNT_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_sel)
        REG_LOOPED: looped <= pwdata[0];
        REG_COUNT: point_count <= pwdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_LOOPED: prdata = 32'(looped);
      REG_COUNT: prdata = 32'(point_count);
      default: prdata = '0;
    endcase
  end

  crs_fetch #(
    .MAX_POINTS(MAX_POINTS),
    .AW(AW)
  ) u_fetch (
    .clk(clk),
    .rst(rst),
    .looped(looped),
    .point_count(point_count),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd(cmd),
    .fch_valid(fch_valid),
    .fch_ready(fch_ready),
    .fch(fch)
  );

  crs_weight u_weight (
    .clk(clk),
    .rst(rst),
    .fch_valid(fch_valid),
    .fch_ready(fch_ready),
    .fch(fch),
    .wgt_valid(wgt_valid),
    .wgt_ready(wgt_ready),
    .wgt(wgt)
  );

  crs_combine u_combine (
    .clk(clk),
    .rst(rst),
    .wgt_valid(wgt_valid),
    .wgt_ready(wgt_ready),
    .wgt(wgt),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res(res)
  );

endmodule

`default_nettype wire

### rtl/crs_checker.sv
// Port-level checks of the spline evaluator and their binding to the top level.
`timescale 1ns / 1ps
`default_nettype none

module crs_checker
  import crs_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic cmd_ready,
  input wire logic res_valid,
  input wire logic res_ready,
  input wire res_t res
);

  a_reset_empties: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("Result valid right after reset.");

  a_empty_output_takes_item: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> cmd_ready)
    else $error("Input stalled although the output register is empty.");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("Stalled result changed or vanished.");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status == ST_RANGE |->
      res.result_x == '0 && res.result_y == '0 && res.result_z == '0)
    else $error("Out-of-range result carries nonzero coordinates.");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res.status == ST_OK || res.status == ST_RANGE || res.status == ST_SAT)
    else $error("Unknown status code.");

endmodule

bind catmull_rom_spline_evaluator crs_checker u_checker (.*);

`default_nettype wire
